/* rtl/txtcon_pkg.sv */
// ----------------------------------------------------------------------------
// txtcon_pkg
// Shared types and constants of the text console character engine: screen
// geometry, command codes, control bytes, payload structs and the
// controller/datapath command and status groups.
// ----------------------------------------------------------------------------
package txtcon_pkg;

  // screen geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int COPY_COUNT = COLUMNS * (ROWS - 1);
  localparam int AW         = $clog2(CELL_COUNT);
  localparam int CW         = (COLUMNS > 2) ? $clog2(COLUMNS) : 1;
  localparam int RW         = $clog2(ROWS + 1);

  // field widths of the channels
  localparam int CMD_W   = 2;
  localparam int CHAR_W  = 8;
  localparam int INDEX_W = 11;
  localparam int POS_W   = 11;
  localparam int ATTR_W  = 8;

  // command codes
  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

  // control and escape bytes
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_M     = 8'h6D;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_THREE = 8'h33;
  localparam logic [7:0] CH_FOUR  = 8'h34;
  localparam logic [7:0] CH_FIVE  = 8'h35;
  localparam logic [7:0] CH_SEVEN = 8'h37;

  // attributes and cells
  localparam logic [ATTR_W-1:0] DEFAULT_ATTR = 8'h07;
  localparam logic [15:0]       BLANK_CELL   = 16'h0700;
  localparam logic [2:0]        STEP_MAX     = 3'd7;

  // foreground colors
  localparam logic [ATTR_W-1:0] FG_RED     = 8'h04;
  localparam logic [ATTR_W-1:0] FG_GREEN   = 8'h02;
  localparam logic [ATTR_W-1:0] FG_YELLOW  = 8'h06;
  localparam logic [ATTR_W-1:0] FG_BLUE    = 8'h01;
  localparam logic [ATTR_W-1:0] FG_MAGENTA = 8'h03;
  localparam logic [ATTR_W-1:0] FG_WHITE   = 8'h07;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [CHAR_W-1:0]  char_byte;
    logic [INDEX_W-1:0] cell_index;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0]  cursor_pos;
    logic [CHAR_W-1:0] cell_char;
    logic [ATTR_W-1:0] cell_attr;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_CLEAR,
    ST_SCR_RD,
    ST_SCR_WR,
    ST_SCR_FILL,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic item_load;
    logic exec_put;
    logic exec_read;
    logic home;
    logic sweep_clr;
    logic fill;
    logic scr_read;
    logic scr_write;
    logic row_dec;
    logic out_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             put_scroll;
    logic             copy_last;
    logic             fill_last;
  } dp_status_t;

endpackage

/* rtl/txtcon_datapath.sv */
// ----------------------------------------------------------------------------
// txtcon_datapath
// Screen store, cursor and escape parser registers, byte interpreter and
// result register. Steps are driven by the controller one command at a time.
// ----------------------------------------------------------------------------
module txtcon_datapath (
  input  logic                   clk,
  input  logic                   rst_n,
  input  txtcon_pkg::in_item_t   in_item,
  input  txtcon_pkg::dp_cmd_t    cmd,
  output txtcon_pkg::dp_status_t status,
  output txtcon_pkg::out_item_t  out_item
);

  // screen store
  logic [15:0] mem [txtcon_pkg::CELL_COUNT];
  logic [15:0] rd_data_r;

  txtcon_pkg::in_item_t  item_r;
  txtcon_pkg::out_item_t out_r;

  logic [txtcon_pkg::CW-1:0]     col_r, col_nxt;
  logic [txtcon_pkg::RW-1:0]     row_r, row_nxt;
  logic [2:0]                    step_r, step_nxt;
  logic [txtcon_pkg::ATTR_W-1:0] cur_attr_r, cur_attr_nxt;
  logic [txtcon_pkg::ATTR_W-1:0] pend_attr_r, pend_attr_nxt;
  logic [txtcon_pkg::AW-1:0]     sweep_r, sweep_nxt;

  logic [txtcon_pkg::AW-1:0] pos;

  // put step results
  logic [txtcon_pkg::CW-1:0]     p_col;
  logic [txtcon_pkg::RW-1:0]     p_row;
  logic [2:0]                    p_step;
  logic [txtcon_pkg::ATTR_W-1:0] p_cur;
  logic [txtcon_pkg::ATTR_W-1:0] p_pend;
  logic                          p_we;
  logic [txtcon_pkg::AW-1:0]     p_wa;
  logic [15:0]                   p_wd;

  logic       dig_hit;
  logic [7:0] dig_fg;
  logic       ent_ok;
  logic [2:0] ent;
  logic [7:0] ch;

  logic                      we;
  logic [txtcon_pkg::AW-1:0] wa;
  logic [15:0]               wd;
  logic                      re;
  logic [txtcon_pkg::AW-1:0] ra;
  logic                      rd_in_range;

  assign ch  = item_r.char_byte;
  assign pos = txtcon_pkg::AW'(row_r * txtcon_pkg::COLUMNS + col_r);

  // color digit decode
  always_comb begin
    dig_hit = 1'b1;
    dig_fg  = txtcon_pkg::FG_WHITE;
    unique case (ch)
      txtcon_pkg::CH_ONE:   dig_fg = txtcon_pkg::FG_RED;
      txtcon_pkg::CH_TWO:   dig_fg = txtcon_pkg::FG_GREEN;
      txtcon_pkg::CH_THREE: dig_fg = txtcon_pkg::FG_YELLOW;
      txtcon_pkg::CH_FOUR:  dig_fg = txtcon_pkg::FG_BLUE;
      txtcon_pkg::CH_FIVE:  dig_fg = txtcon_pkg::FG_MAGENTA;
      txtcon_pkg::CH_SEVEN: dig_fg = txtcon_pkg::FG_WHITE;
      default:              dig_hit = 1'b0;
    endcase
  end

  // entry point into the escape test chain
  always_comb begin
    ent_ok = 1'b1;
    ent    = 3'd0;
    unique case (ch)
      txtcon_pkg::CH_LBRK:  ent = 3'd0;
      txtcon_pkg::CH_ZERO:  ent = 3'd1;
      txtcon_pkg::CH_SEMI:  ent = 3'd2;
      txtcon_pkg::CH_M:     ent = 3'd3;
      txtcon_pkg::CH_THREE: ent = 3'd4;
      default:              ent_ok = 1'b0;
    endcase
  end

  // byte interpreter
  always_comb begin
    logic chain_hit;
    chain_hit = 1'b0;
    p_col  = col_r;
    p_row  = row_r;
    p_step = step_r;
    p_cur  = cur_attr_r;
    p_pend = pend_attr_r;
    p_we   = 1'b0;
    p_wa   = pos;
    p_wd   = txtcon_pkg::BLANK_CELL;
    if (step_r == 3'd5 && dig_hit) begin
      p_pend = dig_fg;
      p_step = 3'd6;
    end else if (ch == txtcon_pkg::CH_ESC) begin
      if (step_r < txtcon_pkg::STEP_MAX) p_step = step_r + 3'd1;
    end else if (ch == txtcon_pkg::CH_CR) begin
      p_step = step_r;
    end else if (ch == txtcon_pkg::CH_LF) begin
      p_we  = 1'b1;
      p_col = '0;
      p_row = row_r + 1'b1;
    end else if (ch == txtcon_pkg::CH_BS) begin
      if (col_r == '0) begin
        p_col = txtcon_pkg::CW'(txtcon_pkg::COLUMNS - 1);
        if (row_r != '0) p_row = row_r - 1'b1;
      end else begin
        p_col = col_r - 1'b1;
      end
      // no clear below cell zero
      p_we = (pos != '0);
      p_wa = pos - 1'b1;
    end else begin
      // escape chain with fall-through order
      if (ent_ok) begin
        priority if (ent == 3'd0 && step_r == 3'd1) begin
          p_step = 3'd2; chain_hit = 1'b1;
        end else if (ent <= 3'd1 && step_r == 3'd2) begin
          p_step = 3'd3; chain_hit = 1'b1;
        end else if (ent <= 3'd2 && step_r == 3'd3) begin
          p_step = 3'd4; chain_hit = 1'b1;
        end else if (ent <= 3'd3 && step_r == 3'd3) begin
          p_step = 3'd0; p_cur = txtcon_pkg::DEFAULT_ATTR; chain_hit = 1'b1;
        end else if (ent <= 3'd3 && step_r == 3'd6) begin
          p_step = 3'd0; p_cur = pend_attr_r; chain_hit = 1'b1;
        end else if (step_r == 3'd4) begin
          p_step = 3'd5; chain_hit = 1'b1;
        end else begin
          chain_hit = 1'b0;
        end
      end
      // printable: write and advance
      if (!chain_hit) begin
        p_we = 1'b1;
        p_wd = {cur_attr_r, ch};
        if (col_r == txtcon_pkg::CW'(txtcon_pkg::COLUMNS - 1)) begin
          p_col = '0;
          p_row = row_r + 1'b1;
        end else begin
          p_col = col_r + 1'b1;
        end
      end
    end
  end

  // next values of the console registers
  always_comb begin
    col_nxt       = col_r;
    row_nxt       = row_r;
    step_nxt      = step_r;
    cur_attr_nxt  = cur_attr_r;
    pend_attr_nxt = pend_attr_r;
    sweep_nxt     = sweep_r;
    if (cmd.exec_put) begin
      col_nxt       = p_col;
      row_nxt       = p_row;
      step_nxt      = p_step;
      cur_attr_nxt  = p_cur;
      pend_attr_nxt = p_pend;
    end
    if (cmd.home) begin
      col_nxt = '0;
      row_nxt = '0;
    end
    if (cmd.row_dec) row_nxt = row_r - 1'b1;
    if (cmd.sweep_clr) begin
      sweep_nxt = '0;
    end else if (cmd.fill || cmd.scr_write) begin
      sweep_nxt = sweep_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      step_r      <= '0;
      cur_attr_r  <= txtcon_pkg::DEFAULT_ATTR;
      pend_attr_r <= '0;
      sweep_r     <= '0;
    end else begin
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      step_r      <= step_nxt;
      cur_attr_r  <= cur_attr_nxt;
      pend_attr_r <= pend_attr_nxt;
      sweep_r     <= sweep_nxt;
    end
  end

  // store port selection
  always_comb begin
    we = 1'b0;
    wa = sweep_r;
    wd = txtcon_pkg::BLANK_CELL;
    if (cmd.fill) begin
      we = 1'b1;
    end else if (cmd.scr_write) begin
      we = 1'b1;
      wd = rd_data_r;
    end else if (cmd.exec_put) begin
      we = p_we;
      wa = p_wa;
      wd = p_wd;
    end
    re = cmd.scr_read || cmd.exec_read;
    ra = cmd.scr_read ? txtcon_pkg::AW'(sweep_r + txtcon_pkg::COLUMNS)
                      : txtcon_pkg::AW'(item_r.cell_index);
  end

  assign rd_in_range = (item_r.cell_index < txtcon_pkg::INDEX_W'(txtcon_pkg::CELL_COUNT));

  // screen store ports
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (re && (cmd.scr_read || rd_in_range)) rd_data_r <= mem[ra];
  end

  // item and result registers
  always_ff @(posedge clk) begin
    if (cmd.item_load) item_r <= in_item;
    if (cmd.out_load) begin
      out_r.cursor_pos <= txtcon_pkg::POS_W'(pos);
      if (item_r.cmd == txtcon_pkg::CMD_READ && rd_in_range) begin
        out_r.cell_char <= rd_data_r[7:0];
        out_r.cell_attr <= rd_data_r[15:8];
      end else begin
        out_r.cell_char <= '0;
        out_r.cell_attr <= '0;
      end
    end
  end

  assign out_item = out_r;

  assign status.cmd        = item_r.cmd;
  assign status.put_scroll = (p_row == txtcon_pkg::RW'(txtcon_pkg::ROWS));
  assign status.copy_last  = (sweep_r == txtcon_pkg::AW'(txtcon_pkg::COPY_COUNT - 1));
  assign status.fill_last  = (sweep_r == txtcon_pkg::AW'(txtcon_pkg::CELL_COUNT - 1));

endmodule

/* rtl/txtcon_ctrl.sv */
// ----------------------------------------------------------------------------
// txtcon_ctrl
// Controller state machine: handshakes, store sweeps for reset, clear and
// scroll, and the result register's valid flag.
// ----------------------------------------------------------------------------
module txtcon_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  txtcon_pkg::dp_status_t status,
  output txtcon_pkg::dp_cmd_t    cmd
);

  txtcon_pkg::state_t state_r, state_nxt;
  logic               out_valid_r, out_valid_nxt;

  // state and valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= txtcon_pkg::ST_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      txtcon_pkg::ST_INIT: begin
        cmd.fill = 1'b1;
        if (status.fill_last) state_nxt = txtcon_pkg::ST_IDLE;
      end
      txtcon_pkg::ST_IDLE: begin
        in_ready       = 1'b1;
        cmd.item_load  = in_valid;
        if (in_valid) state_nxt = txtcon_pkg::ST_EXEC;
      end
      txtcon_pkg::ST_EXEC: begin
        cmd.sweep_clr = 1'b1;
        unique case (status.cmd)
          txtcon_pkg::CMD_PUT: begin
            cmd.exec_put = 1'b1;
            state_nxt    = status.put_scroll ? txtcon_pkg::ST_SCR_RD : txtcon_pkg::ST_DONE;
          end
          txtcon_pkg::CMD_READ: begin
            cmd.exec_read = 1'b1;
            state_nxt     = txtcon_pkg::ST_DONE;
          end
          txtcon_pkg::CMD_CLEAR: begin
            cmd.home  = 1'b1;
            state_nxt = txtcon_pkg::ST_CLEAR;
          end
          txtcon_pkg::CMD_NOP: state_nxt = txtcon_pkg::ST_DONE;
          default:             state_nxt = txtcon_pkg::ST_DONE;
        endcase
      end
      txtcon_pkg::ST_CLEAR: begin
        cmd.fill = 1'b1;
        if (status.fill_last) state_nxt = txtcon_pkg::ST_DONE;
      end
      txtcon_pkg::ST_SCR_RD: begin
        cmd.scr_read = 1'b1;
        state_nxt    = txtcon_pkg::ST_SCR_WR;
      end
      txtcon_pkg::ST_SCR_WR: begin
        cmd.scr_write = 1'b1;
        state_nxt     = status.copy_last ? txtcon_pkg::ST_SCR_FILL : txtcon_pkg::ST_SCR_RD;
      end
      txtcon_pkg::ST_SCR_FILL: begin
        cmd.fill = 1'b1;
        if (status.fill_last) begin
          cmd.row_dec = 1'b1;
          state_nxt   = txtcon_pkg::ST_DONE;
        end
      end
      txtcon_pkg::ST_DONE: begin
        // result slot frees when empty or being taken
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = txtcon_pkg::ST_IDLE;
        end
      end
      default: state_nxt = txtcon_pkg::ST_IDLE;
    endcase
  end

  // result valid
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* rtl/text_console_char_engine.sv */
// Put, read, unused command: the beat is taken in idle, executed, and the result registered in done.
// A put that scrolls first copies rows up by one, a read and a write per cell, then blanks the last row.
// Clear sweeps the whole store with blank cells before its result.
// One item at a time; the next beat is taken while a result waits.
// After reset the screen store is cleared by a sweep over every cell,
// during which no input beat is taken.
// ----------------------------------------------------------------------------
// text_console_char_engine
// Character-cell text console: byte interpreter with color escapes, cursor,
// scrolling, cell read and screen clear over a screen store with one write and one read port.
// ----------------------------------------------------------------------------
module text_console_char_engine (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  txtcon_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output txtcon_pkg::out_item_t out_data
);

  txtcon_pkg::dp_cmd_t    dp_cmd;
  txtcon_pkg::dp_status_t dp_status;

  // sequencing
  txtcon_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (dp_status),
    .cmd       (dp_cmd)
  );

  // store and console registers
  txtcon_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_data),
    .cmd      (dp_cmd),
    .status   (dp_status),
    .out_item (out_data)
  );

endmodule

/* tb/text_console_char_engine_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_char_engine_test
// Self-checking bench for the text console engine. A queue of command beats
// (directed corner cases, then random text, color escapes, control bytes,
// reads, clears) feeds a bursty sender; a predictor of the screen, cursor and
// escape parser runs on every accepted beat, and each result beat taken by a
// stalling receiver is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module text_console_char_engine_test;
  import txtcon_pkg::*;

  // what one put byte does to the console
  typedef enum logic [3:0] {
    ACT_COLOR,
    ACT_ESC,
    ACT_IGNORE,
    ACT_LF,
    ACT_BS,
    ACT_ATTR_DEFAULT,
    ACT_ATTR_PENDING,
    ACT_STEP,
    ACT_PRINT
  } byte_act_e;

  // receiver stall patterns
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_PULSE
  } rx_mode_e;

  logic      clk      = 1'b0;
  logic      rst_n    = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data  = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  text_console_char_engine u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // console state as the predictor sees it
  logic [15:0] cell_mem [CELL_COUNT];
  int unsigned cur_col;
  int unsigned cur_row;
  logic [2:0]  parse_step;
  logic [7:0]  text_attr;
  logic [7:0]  color_attr;

  // escape step as the stimulus builder tracks it
  logic [2:0]  gen_step;

  in_item_t    cmd_q [$];
  out_item_t   report_q [$];
  int unsigned mismatches = 0;

  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned rx_hold;
  int unsigned rx_tick;
  rx_mode_e    rx_mode;

  initial begin
    forever #10 clk = ~clk;
  end

  // decode of one put byte against the escape step, in the chain's order
  function automatic byte_act_e classify(input logic [2:0] st, input logic [7:0] ch,
                                         output logic [2:0] nst, output logic [7:0] fg);
    int entry;
    nst = st;
    fg  = '0;
    if (st == 3'd5) begin
      case (ch)
        CH_ONE:   fg = FG_RED;
        CH_TWO:   fg = FG_GREEN;
        CH_THREE: fg = FG_YELLOW;
        CH_FOUR:  fg = FG_BLUE;
        CH_FIVE:  fg = FG_MAGENTA;
        CH_SEVEN: fg = FG_WHITE;
        default:  fg = '0;
      endcase
      if (fg != '0) begin
        nst = 3'd6;
        return ACT_COLOR;
      end
    end
    if (ch == CH_ESC) begin
      if (st != STEP_MAX) nst = st + 3'd1;
      return ACT_ESC;
    end
    if (ch == CH_CR) return ACT_IGNORE;
    if (ch == CH_LF) return ACT_LF;
    if (ch == CH_BS) return ACT_BS;
    // escape bytes enter the chain at their own test and fall through
    case (ch)
      CH_LBRK:  entry = 0;
      CH_ZERO:  entry = 1;
      CH_SEMI:  entry = 2;
      CH_M:     entry = 3;
      CH_THREE: entry = 4;
      default:  entry = 5;
    endcase
    if (entry < 5) begin
      if (entry <= 0 && st == 3'd1) begin
        nst = 3'd2;
        return ACT_STEP;
      end
      if (entry <= 1 && st == 3'd2) begin
        nst = 3'd3;
        return ACT_STEP;
      end
      if (entry <= 2 && st == 3'd3) begin
        nst = 3'd4;
        return ACT_STEP;
      end
      if (entry <= 3 && st == 3'd3) begin
        nst = 3'd0;
        return ACT_ATTR_DEFAULT;
      end
      if (entry <= 3 && st == 3'd6) begin
        nst = 3'd0;
        return ACT_ATTR_PENDING;
      end
      if (st == 3'd4) begin
        nst = 3'd5;
        return ACT_STEP;
      end
    end
    return ACT_PRINT;
  endfunction

  function automatic void blank_from(input int unsigned first);
    for (int unsigned i = first; i < CELL_COUNT; i++) cell_mem[i] = BLANK_CELL;
  endfunction

  // apply one command beat to the console and form its report
  task automatic console_apply(input in_item_t it, output out_item_t res);
    int unsigned pos;
    byte_act_e   act;
    logic [2:0]  nxt;
    logic [7:0]  fg;
    res = '0;
    pos = cur_row * COLUMNS + cur_col;
    case (it.cmd)
      CMD_PUT: begin
        act = classify(parse_step, it.char_byte, nxt, fg);
        parse_step = nxt;
        case (act)
          ACT_COLOR:        color_attr = fg;
          ACT_ATTR_DEFAULT: text_attr = DEFAULT_ATTR;
          ACT_ATTR_PENDING: text_attr = color_attr;
          ACT_LF: begin
            cell_mem[pos] = BLANK_CELL;
            cur_col = 0;
            cur_row++;
          end
          ACT_BS: begin
            if (cur_col == 0) begin
              cur_col = COLUMNS - 1;
              if (cur_row > 0) cur_row--;
            end else begin
              cur_col--;
            end
            // at the origin there is no cell before the cursor
            if (pos > 0) cell_mem[pos - 1] = BLANK_CELL;
          end
          ACT_PRINT: begin
            cell_mem[pos] = {text_attr, it.char_byte};
            cur_col++;
            if (cur_col > COLUMNS - 1) begin
              cur_col = 0;
              cur_row++;
            end
          end
          default: ;
        endcase
        // scroll up one row past the bottom
        while (cur_row > ROWS - 1) begin
          for (int unsigned i = 0; i < COPY_COUNT; i++) cell_mem[i] = cell_mem[i + COLUMNS];
          blank_from(COPY_COUNT);
          cur_row--;
        end
      end
      CMD_READ: begin
        if (it.cell_index < CELL_COUNT) {res.cell_attr, res.cell_char} = cell_mem[it.cell_index];
      end
      CMD_CLEAR: begin
        blank_from(0);
        cur_col = 0;
        cur_row = 0;
      end
      default: ;
    endcase
    res.cursor_pos = POS_W'(cur_row * COLUMNS + cur_col);
  endtask

  // stimulus building
  task automatic push_item(input logic [CMD_W-1:0] cmd, input logic [7:0] ch,
                           input logic [INDEX_W-1:0] idx);
    in_item_t it;
    it.cmd        = cmd;
    it.char_byte  = ch;
    it.cell_index = idx;
    cmd_q.push_back(it);
  endtask

  task automatic push_put(input logic [7:0] ch);
    logic [2:0] nxt;
    logic [7:0] fg;
    void'(classify(gen_step, ch, nxt, fg));
    gen_step = nxt;
    push_item(CMD_PUT, ch, INDEX_W'($urandom_range(0, 2047)));
  endtask

  function automatic logic [7:0] plain_byte(input bit printable);
    logic [7:0] ch;
    do begin
      ch = printable ? 8'($urandom_range(8'h20, 8'h7E)) : 8'($urandom_range(0, 255));
    end while (ch == CH_ESC);
    return ch;
  endfunction

  // walk a half-finished escape back to step zero
  task automatic sync_escape();
    while (gen_step != 3'd0 && gen_step != STEP_MAX) begin
      case (gen_step)
        3'd1:    push_put(CH_LBRK);
        3'd2:    push_put(CH_ZERO);
        3'd3:    push_put(CH_M);
        3'd4:    push_put(CH_THREE);
        3'd5:    push_put(CH_ONE);
        default: push_put(CH_M);
      endcase
    end
  endtask

  // sender: bursts of beats with gaps, payload held until taken
  always @(posedge clk) begin : drive_blk
    out_item_t res;
    if (!rst_n) begin
      in_valid   <= 1'b0;
      in_data    <= '0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (in_valid && in_ready) begin
        console_apply(in_data, res);
        report_q.push_back(res);
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (cmd_q.size() != 0) begin
          in_valid <= 1'b1;
          in_data  <= cmd_q.pop_front();
          if (burst_left > 1) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(1, 40);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern is redrawn whenever its random hold runs out
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_hold   <= 0;
      rx_tick   <= 0;
      rx_mode   <= RX_OPEN;
    end else begin
      rx_tick <= rx_tick + 1;
      if (rx_hold == 0) begin
        rx_mode <= rx_mode_e'($urandom_range(0, 3));
        rx_hold <= $urandom_range(20, 300);
      end else begin
        rx_hold <= rx_hold - 1;
      end
      case (rx_mode)
        RX_OPEN:   out_ready <= 1'b1;
        RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
        default:   out_ready <= rx_tick[2];
      endcase
    end
  end

  // result beats against the oldest prediction
  always @(posedge clk) begin : check_blk
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (report_q.size() == 0) begin
        $display("%0t: unexpected result, cursor_pos %0d cell_char %h cell_attr %h",
                 $time, out_data.cursor_pos, out_data.cell_char, out_data.cell_attr);
        mismatches++;
      end else begin
        want = report_q.pop_front();
        if (out_data.cursor_pos !== want.cursor_pos) begin
          $display("%0t: cursor_pos expected %0d got %0d",
                   $time, want.cursor_pos, out_data.cursor_pos);
          mismatches++;
        end
        if (out_data.cell_char !== want.cell_char) begin
          $display("%0t: cell_char expected %h got %h",
                   $time, want.cell_char, out_data.cell_char);
          mismatches++;
        end
        if (out_data.cell_attr !== want.cell_attr) begin
          $display("%0t: cell_attr expected %h got %h",
                   $time, want.cell_attr, out_data.cell_attr);
          mismatches++;
        end
      end
    end
  end

  // stimulus, reset and end of run
  initial begin
    int unsigned target;
    int unsigned pick;
    int unsigned n;
    logic [7:0]  seq [7];

    blank_from(0);
    cur_col    = 0;
    cur_row    = 0;
    parse_step = '0;
    gen_step   = '0;
    text_attr  = DEFAULT_ATTR;
    color_attr = '0;

    // corners: reads at the ends of the store and past it
    push_item(CMD_READ, 8'h00, 11'd0);
    push_item(CMD_READ, 8'hFF, 11'(CELL_COUNT - 1));
    push_item(CMD_READ, 8'h5A, 11'(CELL_COUNT));
    push_item(CMD_READ, 8'hA5, 11'h7FF);
    // backspace at the origin, carriage return, wrap off the last column
    push_put(CH_BS);
    push_put(CH_CR);
    push_put(8'h41);
    push_put(8'hFF);
    // red foreground, one char in it, then back to default
    push_put(CH_ESC);
    push_put(CH_LBRK);
    push_put(CH_ZERO);
    push_put(CH_SEMI);
    push_put(CH_THREE);
    push_put(CH_ONE);
    push_put(CH_M);
    push_put(8'h42);
    push_put(CH_ESC);
    push_put(CH_LBRK);
    push_put(CH_ZERO);
    push_put(CH_M);
    // newline, then backspace up into the row above
    push_put(CH_LF);
    push_put(CH_BS);
    push_item(CMD_READ, 8'h00, 11'(COLUMNS + 1));
    push_item(CMD_NOP, 8'hFF, 11'h7FF);
    push_item(CMD_CLEAR, 8'hFF, 11'h7FF);

    // random part: mostly escapes and text, with line feeds to reach scrolling
    target = cmd_q.size() + 550;
    while (cmd_q.size() < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        sync_escape();
        push_put(CH_ESC);
        push_put(CH_LBRK);
        push_put(CH_ZERO);
        if ($urandom_range(0, 3) != 0) begin
          push_put(CH_SEMI);
          push_put(CH_THREE);
          push_put(CH_ZERO + 8'($urandom_range(0, 9)));
        end
        push_put(CH_M);
      end else if (pick < 35) begin
        // sequence cut short by a stray byte
        sync_escape();
        seq = '{CH_ESC, CH_LBRK, CH_ZERO, CH_SEMI, CH_THREE,
                CH_ZERO + 8'($urandom_range(0, 9)), CH_M};
        n = $urandom_range(1, 5);
        for (int unsigned i = 0; i < n; i++) push_put(seq[i]);
        push_put(plain_byte(1'b0));
      end else if (pick < 52) begin
        n = $urandom_range(1, 12);
        repeat (n) push_put(plain_byte($urandom_range(0, 3) != 0));
      end else if (pick < 62) begin
        repeat ($urandom_range(1, 4)) push_put(CH_LF);
      end else if (pick < 67) begin
        repeat ($urandom_range(1, 3)) push_put(CH_BS);
      end else if (pick < 69) begin
        push_put(CH_CR);
      end else if (pick < 72) begin
        // keep the parser below its top step until the tail
        if (gen_step < 3'd6) repeat ($urandom_range(1, 6 - gen_step)) push_put(CH_ESC);
      end else if (pick < 90) begin
        case ($urandom_range(0, 5))
          0, 1:    n = $urandom_range(0, 399);
          2, 3:    n = $urandom_range(0, CELL_COUNT - 1);
          4:       n = $urandom_range(CELL_COUNT - 5 * COLUMNS, CELL_COUNT - 1);
          default: n = $urandom_range(0, 2047);
        endcase
        push_item(CMD_READ, 8'($urandom_range(0, 255)), INDEX_W'(n));
      end else if (pick < 92) begin
        push_item(CMD_NOP, 8'($urandom_range(0, 255)), INDEX_W'($urandom_range(0, 2047)));
      end else if (pick < 93) begin
        push_item(CMD_CLEAR, 8'($urandom_range(0, 255)), INDEX_W'($urandom_range(0, 2047)));
      end else begin
        push_put(plain_byte(1'b0));
      end
    end

    // escape step pinned at its top: sequences no longer decode
    sync_escape();
    repeat (8) push_put(CH_ESC);
    push_put(CH_LBRK);
    push_put(CH_ZERO);
    push_put(CH_M);
    push_item(CMD_READ, 8'h00, 11'd0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    while (cmd_q.size() != 0 || in_valid || report_q.size() != 0) @(negedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // hang guard: ~600 beats, each at worst a scroll plus gap and stall, come to ~52 ms,
  // plus the clearing pass after reset; allow several times that
  initial begin
    #250_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
